>>> design/ifse_pkg.sv
// Package: shared types, constants and helpers for the IMU frame scaler with accel smoothing
`timescale 1ns / 1ps
`default_nettype none

package ifse_pkg;

    // Frame layout
    localparam int FRAME_LENGTH = 14;
    localparam int POS_W        = 4;
    localparam logic [POS_W-1:0] LAST_POS = 4'(FRAME_LENGTH - 1);

    // Reading index within a frame
    localparam int ELEM_W = 3;
    localparam logic [ELEM_W-1:0] ELEM_TEMP   = 3'd0;
    localparam logic [ELEM_W-1:0] ELEM_ACC_X  = 3'd1;
    localparam logic [ELEM_W-1:0] ELEM_ACC_Y  = 3'd2;
    localparam logic [ELEM_W-1:0] ELEM_ACC_Z  = 3'd3;
    localparam logic [ELEM_W-1:0] ELEM_GYRO_X = 3'd4;
    localparam logic [ELEM_W-1:0] ELEM_GYRO_Y = 3'd5;
    localparam logic [ELEM_W-1:0] ELEM_GYRO_Z = 3'd6;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_EMA_ALPHA   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_SCALE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_SCALE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_SCALE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_OFFSET = 3'd4;

    // Configuration reset values
    localparam logic [16:0]        RST_EMA_ALPHA   = 17'd13107;
    localparam logic [19:0]        RST_ACCEL_SCALE = 20'd321344;
    localparam logic [19:0]        RST_GYRO_SCALE  = 20'd255750;
    localparam logic [19:0]        RST_TEMP_SCALE  = 20'd126640;
    localparam logic signed [17:0] RST_TEMP_OFFSET = 18'sd6400;

    // Result range
    localparam int SAT_IN_W = 24;
    localparam logic signed [SAT_IN_W-1:0] W20_MAX = 24'sd524287;
    localparam logic signed [SAT_IN_W-1:0] W20_MIN = -24'sd524288;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_restart;
    } t_in_word;

    typedef struct packed {
        logic signed [19:0] temperature;
        logic signed [19:0] accel_x_smooth;
        logic signed [19:0] accel_y_smooth;
        logic signed [19:0] accel_z_smooth;
        logic signed [19:0] rate_x;
        logic signed [19:0] rate_y;
        logic signed [19:0] rate_z;
    } t_out_word;

    // Controller to datapath commands
    typedef struct packed {
        logic              store_en;
        logic [POS_W-1:0]  store_idx;
        logic [ELEM_W-1:0] elem;
        logic              mul_en;
        logic              scl_en;
        logic              bypass;
        logic              emul_en;
        logic              eadd_en;
        logic              out_load;
    } t_cmd;

    // Clamp to 20 bits signed
    function automatic logic signed [19:0] sat20(input logic signed [SAT_IN_W-1:0] v);
        logic signed [19:0] r;
        if (v > W20_MAX) begin
            r = W20_MAX[19:0];
        end else if (v < W20_MIN) begin
            r = W20_MIN[19:0];
        end else begin
            r = v[19:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/imu_frame_scale_ema.sv
// Top level: IMU burst decoder with Q4.16 scaling and accelerometer EMA
// Bytes 1 to 13 of a frame are taken one per cycle; after the 14th the input stalls
// while the shared multiplier walks the seven readings: a multiply step and a scale step
// per reading, plus an EMA multiply step and add step per accel axis once the filter is
// primed. The output word is then loaded as soon as the output register has drained.
// Synchronous active-low reset restores default config and unprimes the filter.
`timescale 1ns / 1ps
`default_nettype none

module imu_frame_scale_ema (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire ifse_pkg::t_in_word              i_in_word,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output ifse_pkg::t_out_word                  o_out_word,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [ifse_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ifse_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ifse_pkg::*;

    t_cmd cmd;

    // Config words are always taken
    assign o_cfg_ready = 1'b1;

    ifse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_restart   (i_in_word.frame_restart),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    ifse_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (i_in_word.data_byte),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

>>> design/ifse_ctrl.sv
// Controller: byte position counter, per-reading sequencer and output handshake
`timescale 1ns / 1ps
`default_nettype none

module ifse_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_restart,
    output logic               o_in_ready,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    output ifse_pkg::t_cmd     o_cmd
);
    import ifse_pkg::*;

    typedef enum logic [5:0] {
        S_COLLECT = 6'b000001,
        S_MUL     = 6'b000010,
        S_SCL     = 6'b000100,
        S_EMUL    = 6'b001000,
        S_EADD    = 6'b010000,
        S_DONE    = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [ELEM_W-1:0]  r_elem, n_elem;
    logic               r_primed, n_primed;
    logic               r_out_valid, n_out_valid;

    logic [POS_W-1:0]   pos_eff;
    logic               in_acc;
    logic               is_accel;
    logic               out_free;

    assign o_in_ready  = (r_state == S_COLLECT);
    assign o_out_valid = r_out_valid;
    assign in_acc      = i_in_valid && o_in_ready;
    assign pos_eff     = i_restart ? '0 : r_pos;
    assign is_accel    = (r_elem == ELEM_ACC_X) || (r_elem == ELEM_ACC_Y) ||
                         (r_elem == ELEM_ACC_Z);
    assign out_free    = !r_out_valid || i_out_ready;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_elem      = r_elem;
        n_primed    = r_primed;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        o_cmd           = '0;
        o_cmd.store_idx = pos_eff;
        o_cmd.elem      = r_elem;
        o_cmd.bypass    = !r_primed;

        case (r_state)
            S_COLLECT: begin
                if (in_acc) begin
                    o_cmd.store_en = 1'b1;
                    if (pos_eff < LAST_POS) begin
                        n_pos = pos_eff + 4'd1;
                    end else begin
                        n_pos   = '0;
                        n_elem  = ELEM_TEMP;
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_SCL;
            end
            S_SCL: begin
                o_cmd.scl_en = 1'b1;
                if (is_accel && r_primed) begin
                    n_state = S_EMUL;
                end else if (r_elem == ELEM_GYRO_Z) begin
                    n_state = S_DONE;
                end else begin
                    n_elem  = r_elem + 3'd1;
                    n_state = S_MUL;
                end
            end
            S_EMUL: begin
                o_cmd.emul_en = 1'b1;
                n_state       = S_EADD;
            end
            S_EADD: begin
                o_cmd.eadd_en = 1'b1;
                n_elem        = r_elem + 3'd1;
                n_state       = S_MUL;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_primed       = 1'b1;
                    n_state        = S_COLLECT;
                end
            end
            default: begin
                n_state = S_COLLECT;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_COLLECT;
            r_pos       <= '0;
            r_elem      <= ELEM_TEMP;
            r_primed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_elem      <= n_elem;
            r_primed    <= n_primed;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

>>> design/ifse_dp.sv
// Datapath: frame byte store, config registers, scale multiplier, EMA filter, output register
`timescale 1ns / 1ps
`default_nettype none

module ifse_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [7:0]                    i_byte,
    input  wire ifse_pkg::t_cmd                i_cmd,
    input  wire logic                          i_cfg_we,
    input  wire logic [ifse_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ifse_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output ifse_pkg::t_out_word                o_out_word
);
    import ifse_pkg::*;

    localparam int PROD_W  = 37;   // 16 x 21 signed
    localparam int EPROD_W = 39;   // 21 x 18 signed

    // Config registers
    logic [16:0]        r_alpha;
    logic [19:0]        r_accel_scale;
    logic [19:0]        r_gyro_scale;
    logic [19:0]        r_temp_scale;
    logic signed [17:0] r_temp_offset;

    // Frame and working registers
    logic [7:0]                r_bytes [FRAME_LENGTH];
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [EPROD_W-1:0] r_eprod;
    logic signed [19:0]        r_x;
    logic signed [19:0]        r_filt [3];
    logic signed [19:0]        r_res  [7];
    t_out_word                 r_out;

    logic [POS_W-1:0]    hi_idx, lo_idx;
    logic signed [15:0]  raw;
    logic [19:0]         scale_sel;
    logic signed [20:0]  scale_s;
    logic signed [20:0]  shifted;
    logic signed [19:0]  scaled_v;
    logic signed [19:0]  temp_v;
    logic [ELEM_W-1:0]   em1;
    logic [1:0]          acc_idx;
    logic signed [19:0]  f_sel;
    logic signed [20:0]  diff;
    logic signed [19:0]  f_new;
    logic                is_accel;

    // Config write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha       <= RST_EMA_ALPHA;
            r_accel_scale <= RST_ACCEL_SCALE;
            r_gyro_scale  <= RST_GYRO_SCALE;
            r_temp_scale  <= RST_TEMP_SCALE;
            r_temp_offset <= RST_TEMP_OFFSET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EMA_ALPHA:   r_alpha       <= i_cfg_data[16:0];
                CFG_ACCEL_SCALE: r_accel_scale <= i_cfg_data;
                CFG_GYRO_SCALE:  r_gyro_scale  <= i_cfg_data;
                CFG_TEMP_SCALE:  r_temp_scale  <= i_cfg_data;
                CFG_TEMP_OFFSET: r_temp_offset <= signed'(i_cfg_data[17:0]);
                default: ;
            endcase
        end
    end

    // Byte store
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_en) begin
            r_bytes[i_cmd.store_idx] <= i_byte;
        end
    end

    // Big-endian reading and its scale
    assign hi_idx   = {i_cmd.elem, 1'b0};
    assign lo_idx   = {i_cmd.elem, 1'b1};
    assign raw      = signed'({r_bytes[hi_idx], r_bytes[lo_idx]});
    assign is_accel = (i_cmd.elem == ELEM_ACC_X) || (i_cmd.elem == ELEM_ACC_Y) ||
                      (i_cmd.elem == ELEM_ACC_Z);

    always_comb begin
        case (i_cmd.elem)
            ELEM_TEMP:                         scale_sel = r_temp_scale;
            ELEM_ACC_X, ELEM_ACC_Y, ELEM_ACC_Z: scale_sel = r_accel_scale;
            default:                           scale_sel = r_gyro_scale;
        endcase
    end
    assign scale_s = signed'({1'b0, scale_sel});

    // Floor shift by 16, clamp, temperature offset
    assign shifted  = r_prod[PROD_W-1:16];
    assign scaled_v = sat20(SAT_IN_W'(shifted));
    assign temp_v   = sat20(SAT_IN_W'(scaled_v) + SAT_IN_W'(r_temp_offset));

    // EMA lane select
    assign em1     = i_cmd.elem - 3'd1;
    assign acc_idx = em1[1:0];
    assign f_sel   = r_filt[acc_idx];
    assign diff    = 21'(r_x) - 21'(f_sel);
    assign f_new   = sat20(SAT_IN_W'(f_sel) + SAT_IN_W'(signed'(r_eprod[EPROD_W-1:16])));

    // Arithmetic steps
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= PROD_W'(raw) * PROD_W'(scale_s);
        end
        if (i_cmd.scl_en) begin
            r_x <= scaled_v;
            if (i_cmd.elem == ELEM_TEMP) begin
                r_res[i_cmd.elem] <= temp_v;
            end else if (!is_accel || i_cmd.bypass) begin
                r_res[i_cmd.elem] <= scaled_v;
            end
            if (is_accel && i_cmd.bypass) begin
                r_filt[acc_idx] <= scaled_v;
            end
        end
        if (i_cmd.emul_en) begin
            r_eprod <= EPROD_W'(diff) * EPROD_W'(signed'({1'b0, r_alpha}));
        end
        if (i_cmd.eadd_en) begin
            r_filt[acc_idx]   <= f_new;
            r_res[i_cmd.elem] <= f_new;
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.temperature    <= r_res[ELEM_TEMP];
            r_out.accel_x_smooth <= r_res[ELEM_ACC_X];
            r_out.accel_y_smooth <= r_res[ELEM_ACC_Y];
            r_out.accel_z_smooth <= r_res[ELEM_ACC_Z];
            r_out.rate_x         <= r_res[ELEM_GYRO_X];
            r_out.rate_y         <= r_res[ELEM_GYRO_Y];
            r_out.rate_z         <= r_res[ELEM_GYRO_Z];
        end
    end

    assign o_out_word = r_out;

endmodule

`default_nettype wire
